// ===== sv/tnt_pkg.sv =====
// Shared types, codes and constants of the task notification table.
package tnt_pkg;

  localparam int unsigned TasksDef = 16;
  localparam int unsigned TaskIdW  = 4;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 40;

  localparam logic [ValueW-1:0] ValueMax = '1;

  typedef enum logic [1:0] {
    CMD_NOTIFY = 2'd0,
    CMD_WAIT   = 2'd1,
    CMD_RESUME = 2'd2,
    CMD_TAKE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_SET_BITS  = 2'd0,
    ACT_OVERWRITE = 2'd1,
    ACT_NO_OVERWR = 2'd2,
    ACT_INCREMENT = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ERROR   = 2'd1,
    ST_BLOCKED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_VALUE = 2'd1,
    MODE_TAKE  = 2'd2
  } mode_e;

  // One slot of the table.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              pending;
    mode_e             mode;
  } entry_t;

  // One decoded request.
  typedef struct packed {
    cmd_e               cmd;
    logic [TaskIdW-1:0] task_id;
    logic               task_alive;
    logic [ValueW-1:0]  notify_data;
    action_e            action;
    logic [ValueW-1:0]  entry_clear_mask;
    logic [ValueW-1:0]  exit_clear_mask;
    logic               take_clear_all;
  } req_t;

  // One result.
  typedef struct packed {
    status_e           status;
    logic [ValueW-1:0] observed;
    logic              wake;
  } res_t;

endpackage

// ===== sv/tnt_state_mem.sv =====
// Slot memory with per-slot valid bits and a registered, write-forwarded read.
module tnt_state_mem #(
  parameter int unsigned Tasks = tnt_pkg::TasksDef,
  parameter int unsigned IdxW  = (Tasks > 1) ? $clog2(Tasks) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  tnt_pkg::entry_t wr_data_i,
  output tnt_pkg::entry_t rd_data_o
);
  import tnt_pkg::*;

  entry_t             mem [Tasks];
  logic [Tasks-1:0]   slot_vld_q;
  entry_t             rd_data_q;
  logic               rd_vld_q;
  logic               fwd;

  // A read in the same cycle as a write to that slot must see the new contents.
  assign fwd = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= fwd ? wr_data_i : mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        slot_vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= fwd || slot_vld_q[rd_addr_i];
      end
    end
  end

  // A slot never written since reset reads as all zero.
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== sv/tnt_cmd_logic.sv =====
// Command evaluation: new slot contents and result for one request.
module tnt_cmd_logic (
  input  tnt_pkg::req_t   req_i,
  input  logic            in_range_i,
  input  tnt_pkg::entry_t entry_i,
  output tnt_pkg::entry_t entry_o,
  output tnt_pkg::res_t   res_o,
  output logic            write_o
);
  import tnt_pkg::*;

  logic              blocked;
  logic [ValueW-1:0] entry_cleared;
  logic [ValueW-1:0] notified;
  logic [ValueW-1:0] taken;
  logic              release_w;

  assign blocked       = (entry_i.mode != MODE_NONE);
  assign entry_cleared = entry_i.value & ~req_i.entry_clear_mask;
  assign taken         = req_i.take_clear_all ? '0 : (entry_i.value - ValueW'(1));

  always_comb begin
    case (req_i.action)
      ACT_SET_BITS:  notified = entry_i.value | req_i.notify_data;
      ACT_INCREMENT: notified = (entry_i.value == ValueMax) ? entry_i.value
                                                            : entry_i.value + ValueW'(1);
      default:       notified = req_i.notify_data;
    endcase
  end

  assign release_w = (entry_i.mode == MODE_VALUE) ||
                     ((entry_i.mode == MODE_TAKE) && (notified != '0));

  always_comb begin
    entry_o        = entry_i;
    res_o.status   = ST_ERROR;
    res_o.observed = '0;
    res_o.wake     = 1'b0;
    write_o        = 1'b0;
    if (in_range_i && req_i.task_alive) begin
      write_o = 1'b1;
      unique case (req_i.cmd)
        CMD_NOTIFY: begin
          if (!((req_i.action == ACT_NO_OVERWR) && entry_i.pending)) begin
            entry_o.value   = notified;
            entry_o.pending = 1'b1;
            res_o.status    = ST_DONE;
            if (release_w) begin
              entry_o.mode = MODE_NONE;
              res_o.wake   = 1'b1;
            end
          end
        end
        CMD_WAIT: begin
          if (!blocked) begin
            if (!entry_i.pending) begin
              entry_o.value = entry_cleared;
              entry_o.mode  = MODE_VALUE;
              res_o.status  = ST_BLOCKED;
            end else begin
              entry_o.value   = entry_cleared & ~req_i.exit_clear_mask;
              entry_o.pending = 1'b0;
              res_o.status    = ST_DONE;
              res_o.observed  = entry_cleared;
            end
          end
        end
        CMD_RESUME: begin
          if (entry_i.pending && !blocked) begin
            entry_o.value   = entry_i.value & ~req_i.exit_clear_mask;
            entry_o.pending = 1'b0;
            res_o.status    = ST_DONE;
            res_o.observed  = entry_i.value;
          end
        end
        CMD_TAKE: begin
          if (!blocked) begin
            if (entry_i.value != '0) begin
              entry_o.value   = taken;
              entry_o.pending = (taken != '0);
              res_o.status    = ST_DONE;
              res_o.observed  = entry_i.value;
            end else begin
              entry_o.mode = MODE_TAKE;
              res_o.status = ST_BLOCKED;
            end
          end
        end
        default: begin
          write_o = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== sv/task_notification_table_unit.sv =====
// Top level of the task notification table: request and result registers.
//
//  Channel  Direction  tuser          tdata
//  s_axis   in         cmd            task_id .. take_clear_all (104 bits)
//  m_axis   out        status         observed, wake (40 bits)
//
// One request per cycle sustained while results are taken; a request is held in
// the request register and its result is registered in the result register,
// from which it can be taken. The slot read happens as the request enters the
// request register and the slot write as the result enters the result register.
// Reset clears the per-slot valid bits at once; no clearing pass is needed.
// While the result register is full and not taken, the request register holds
// and s_axis_tready falls once it is full too.
module task_notification_table_unit #(
  parameter int unsigned Tasks = tnt_pkg::TasksDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [1:0] cmd
  input  logic [1:0]                   s_axis_tuser,
  // [3:0] task_id, [4] task_alive, [36:5] notify_data, [38:37] action,
  // [70:39] entry_clear_mask, [102:71] exit_clear_mask, [103] take_clear_all
  input  logic [tnt_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] status
  output logic [1:0]                   m_axis_tuser,
  // [31:0] observed, [32] wake, [39:33] zero
  output logic [tnt_pkg::OutDataW-1:0] m_axis_tdata
);
  import tnt_pkg::*;

  localparam int unsigned IdxW = (Tasks > 1) ? $clog2(Tasks) : 1;
  localparam int unsigned ExtW = IdxW + TaskIdW;

  req_t            req_in;
  req_t            req_q;
  logic            req_vld_q;
  res_t            res_d;
  res_t            res_q;
  logic            res_vld_q;
  logic            advance;
  logic            accept;
  logic [ExtW-1:0] in_ext;
  logic [ExtW-1:0] q_ext;
  logic            in_range_in;
  logic            in_range_q;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_addr;
  logic            write_req;
  entry_t          entry_rd;
  entry_t          entry_wr;

  assign req_in.cmd              = cmd_e'(s_axis_tuser);
  assign req_in.task_id          = s_axis_tdata[3:0];
  assign req_in.task_alive       = s_axis_tdata[4];
  assign req_in.notify_data      = s_axis_tdata[36:5];
  assign req_in.action           = action_e'(s_axis_tdata[38:37]);
  assign req_in.entry_clear_mask = s_axis_tdata[70:39];
  assign req_in.exit_clear_mask  = s_axis_tdata[102:71];
  assign req_in.take_clear_all   = s_axis_tdata[103];

  assign advance       = req_vld_q && (!res_vld_q || m_axis_tready);
  assign s_axis_tready = !req_vld_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Slot indexes; an out-of-range id reads slot zero and never writes.
  assign in_ext      = ExtW'(req_in.task_id);
  assign in_range_in = (in_ext < ExtW'(Tasks));
  assign rd_addr     = in_range_in ? in_ext[IdxW-1:0] : '0;
  assign q_ext       = ExtW'(req_q.task_id);
  assign in_range_q  = (q_ext < ExtW'(Tasks));
  assign wr_addr     = q_ext[IdxW-1:0];

  tnt_state_mem #(
    .Tasks (Tasks),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .wr_en_i   (advance && write_req),
    .wr_addr_i (wr_addr),
    .wr_data_i (entry_wr),
    .rd_data_o (entry_rd)
  );

  tnt_cmd_logic u_cmd (
    .req_i      (req_q),
    .in_range_i (in_range_q),
    .entry_i    (entry_rd),
    .entry_o    (entry_wr),
    .res_o      (res_d),
    .write_o    (write_req)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        req_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_in;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {(OutDataW - ValueW - 1)'(0), res_q.wake, res_q.observed};

  // A wake is only ever reported by a notify that completed.
  a_wake_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.wake) |-> (res_q.status == ST_DONE))
    else $error("wake raised on a result that is not done");

  // Errors and newly blocked callers see no value.
  a_quiet_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res_q.status == ST_ERROR || res_q.status == ST_BLOCKED))
      |-> (res_q.observed == '0 && !res_q.wake))
    else $error("error or blocked result carries data");

  // Backpressure on the input only arises from a full pipeline.
  a_ready_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (req_vld_q && res_vld_q && !m_axis_tready))
    else $error("input stalled while the pipeline can move");

  // A stalled result stays in place until taken.
  a_result_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(res_q)))
    else $error("pending result changed before it was taken");

endmodule
